### src/atom_id_translation_table_defines.svh
// ---------------------------------------------------------------------------
// Atom id translation table assertion macros
// Shared assertion forms for the translation table checks.
// ---------------------------------------------------------------------------
`ifndef ATOM_ID_TRANSLATION_TABLE_DEFINES_SVH
`define ATOM_ID_TRANSLATION_TABLE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define AIDTT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define AIDTT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

### src/aidtt_pkg.sv
// ---------------------------------------------------------------------------
// Atom id translation table package
// Sizes, request kinds, controller states and control structs.
// ---------------------------------------------------------------------------
package aidtt_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int KEY_W         = 32;
  localparam int NUM_W         = 16;
  localparam int ENTRY_W       = KEY_W + NUM_W;
  localparam logic [NUM_W-1:0] FIRST_NUMBER_RESET = NUM_W'(20000);

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_FWD = 2'd1,
    KIND_REV = 2'd2,
    KIND_CLR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic issue_done;
    logic rsp_free;
  } dp_status_t;

endpackage

### src/atom_id_translation_table.sv
// ---------------------------------------------------------------------------
// Atom id translation table: takes a new request only once the last one is finished;
// a request scans all n filled entries (up to 256), while a clear skips the scan.
// The scan reads one entry per cycle through the entry RAM's single read port.
// Reset empties the table at once (fill count); counter and base go to 20000.
// ---------------------------------------------------------------------------
`include "atom_id_translation_table_defines.svh"

module atom_id_translation_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [1:0]                    kind,
  input  logic [aidtt_pkg::KEY_W-1:0]   internal_id,
  input  logic [aidtt_pkg::NUM_W-1:0]   external_number,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [aidtt_pkg::KEY_W-1:0]   result_value,
  output logic                          found,
  output logic                          table_full,
  output logic                          is_empty,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [aidtt_pkg::NUM_W-1:0]   cfg_data
);

  aidtt_pkg::ctrl_cmd_t  cmd;
  aidtt_pkg::dp_status_t status;

  assign cfg_ready = !rst;

  aidtt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  aidtt_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_wr          (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .kind            (kind),
    .internal_id     (internal_id),
    .external_number (external_number),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .result_value    (result_value),
    .found           (found),
    .table_full      (table_full),
    .is_empty        (is_empty)
  );

  `AIDTT_ASSERT_NEXT(a_req_blocks_next, clk, rst, req_valid && !req_stall, req_stall)
  `AIDTT_ASSERT_NOW(a_finish_needs_room, clk, rst, cmd.finish, status.rsp_free)
  `AIDTT_ASSERT_NOW(a_rsp_from_finish, clk, rst, $rose(rsp_valid), $past(cmd.finish))
  `AIDTT_ASSERT_NOW(a_one_cmd, clk, rst, 1'b1, $onehot0(cmd))

endmodule

### src/aidtt_ram.sv
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module aidtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/aidtt_datapath.sv
// ---------------------------------------------------------------------------
// Atom id translation table datapath
// Entry RAM, fill count, allocation counter, scan compare and result register.
// ---------------------------------------------------------------------------
module aidtt_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  aidtt_pkg::ctrl_cmd_t          cmd,
  output aidtt_pkg::dp_status_t         status,
  input  logic                          cfg_wr,
  input  logic [aidtt_pkg::NUM_W-1:0]   cfg_data,
  input  logic [1:0]                    kind,
  input  logic [aidtt_pkg::KEY_W-1:0]   internal_id,
  input  logic [aidtt_pkg::NUM_W-1:0]   external_number,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [aidtt_pkg::KEY_W-1:0]   result_value,
  output logic                          found,
  output logic                          table_full,
  output logic                          is_empty
);

  aidtt_pkg::kind_t                 kind_q;
  logic [aidtt_pkg::KEY_W-1:0]      id_q;
  logic [aidtt_pkg::NUM_W-1:0]      num_q;
  logic [aidtt_pkg::CNT_W-1:0]      cnt;
  logic [aidtt_pkg::CNT_W-1:0]      cnt_next;
  logic [aidtt_pkg::CNT_W-1:0]      rd_idx;
  logic [aidtt_pkg::NUM_W-1:0]      next_number;
  logic [aidtt_pkg::NUM_W-1:0]      next_number_next;
  logic [aidtt_pkg::NUM_W-1:0]      base;
  logic                             cmp_pend;
  logic                             hit;
  logic [aidtt_pkg::KEY_W-1:0]      hit_value;
  logic [aidtt_pkg::ENTRY_W-1:0]    rd_data;
  logic [aidtt_pkg::KEY_W-1:0]      rd_key;
  logic [aidtt_pkg::NUM_W-1:0]      rd_num;
  logic                             wr_en;
  logic [aidtt_pkg::KEY_W-1:0]      res_value;
  logic                             res_found;
  logic                             res_full;
  logic                             tbl_full;

  aidtt_ram #(
    .WIDTH (aidtt_pkg::ENTRY_W),
    .DEPTH (aidtt_pkg::TABLE_ENTRIES)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt[aidtt_pkg::IDX_W-1:0]),
    .wr_data ({id_q, next_number}),
    .rd_en   (cmd.issue),
    .rd_addr (rd_idx[aidtt_pkg::IDX_W-1:0]),
    .rd_data (rd_data)
  );

  assign rd_key   = rd_data[aidtt_pkg::ENTRY_W-1:aidtt_pkg::NUM_W];
  assign rd_num   = rd_data[aidtt_pkg::NUM_W-1:0];
  assign tbl_full = (cnt == aidtt_pkg::CNT_W'(aidtt_pkg::TABLE_ENTRIES));

  assign status.is_clear   = (kind_q == aidtt_pkg::KIND_CLR);
  assign status.issue_done = (rd_idx == cnt);
  assign status.rsp_free   = !rsp_valid || !rsp_stall;

  // Result of the finished scan and the table update it implies.
  always_comb begin
    res_value        = '0;
    res_found        = 1'b0;
    res_full         = 1'b0;
    wr_en            = 1'b0;
    cnt_next         = cnt;
    next_number_next = next_number;
    unique case (kind_q)
      aidtt_pkg::KIND_ADD: begin
        if (hit) begin
          res_value = hit_value;
          res_found = 1'b1;
        end else if (tbl_full) begin
          res_full  = 1'b1;
          res_value = {{(aidtt_pkg::KEY_W-aidtt_pkg::NUM_W){1'b0}},
                       id_q[aidtt_pkg::NUM_W-1:0]};
        end else begin
          wr_en            = cmd.finish;
          res_value        = {{(aidtt_pkg::KEY_W-aidtt_pkg::NUM_W){1'b0}}, next_number};
          cnt_next         = cnt + aidtt_pkg::CNT_W'(1);
          next_number_next = next_number + aidtt_pkg::NUM_W'(1);
        end
      end
      aidtt_pkg::KIND_FWD: begin
        res_found = hit;
        res_value = hit ? hit_value
                        : {{(aidtt_pkg::KEY_W-aidtt_pkg::NUM_W){1'b0}},
                           id_q[aidtt_pkg::NUM_W-1:0]};
      end
      aidtt_pkg::KIND_REV: begin
        res_found = hit;
        res_value = hit ? hit_value
                        : {{(aidtt_pkg::KEY_W-aidtt_pkg::NUM_W){1'b0}}, num_q};
      end
      aidtt_pkg::KIND_CLR: begin
        cnt_next         = '0;
        next_number_next = base;
      end
      default: begin
        res_value = '0;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt         <= '0;
      next_number <= aidtt_pkg::FIRST_NUMBER_RESET;
      base        <= aidtt_pkg::FIRST_NUMBER_RESET;
      cmp_pend    <= 1'b0;
      rsp_valid   <= 1'b0;
      rd_idx      <= '0;
    end else begin
      cmp_pend <= cmd.issue;
      if (cfg_wr) begin
        base <= cfg_data;
      end
      if (cmd.load) begin
        rd_idx <= '0;
      end else if (cmd.issue) begin
        rd_idx <= rd_idx + aidtt_pkg::CNT_W'(1);
      end
      if (cmd.finish) begin
        cnt         <= cnt_next;
        next_number <= next_number_next;
        rsp_valid   <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Request capture, scan compare and result payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= aidtt_pkg::kind_t'(kind);
      id_q   <= internal_id;
      num_q  <= external_number;
      hit    <= 1'b0;
    end else if (cmp_pend) begin
      if (kind_q == aidtt_pkg::KIND_REV) begin
        // keep the smallest id among entries carrying this number
        if (rd_num == num_q && (!hit || rd_key < hit_value)) begin
          hit       <= 1'b1;
          hit_value <= rd_key;
        end
      end else if (rd_key == id_q) begin
        hit       <= 1'b1;
        hit_value <= {{(aidtt_pkg::KEY_W-aidtt_pkg::NUM_W){1'b0}}, rd_num};
      end
    end
    if (cmd.finish) begin
      result_value <= res_value;
      found        <= res_found;
      table_full   <= res_full;
      is_empty     <= (next_number_next == base);
    end
  end

endmodule

### src/aidtt_ctrl.sv
// ---------------------------------------------------------------------------
// Atom id translation table controller
// Sequences request capture, entry scan, drain and result write.
// ---------------------------------------------------------------------------
module aidtt_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  aidtt_pkg::dp_status_t  status,
  output aidtt_pkg::ctrl_cmd_t   cmd
);

  aidtt_pkg::state_t state;
  aidtt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aidtt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    unique case (state)
      aidtt_pkg::ST_IDLE: begin
        // hold off requests while in reset
        req_stall = rst;
        if (req_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = aidtt_pkg::ST_SCAN;
        end
      end
      aidtt_pkg::ST_SCAN: begin
        if (status.is_clear) begin
          state_next = aidtt_pkg::ST_FINISH;
        end else if (status.issue_done) begin
          state_next = aidtt_pkg::ST_DRAIN;
        end else begin
          cmd.issue = 1'b1;
        end
      end
      // last compare has already landed in hit
      aidtt_pkg::ST_DRAIN: begin
        state_next = aidtt_pkg::ST_FINISH;
      end
      aidtt_pkg::ST_FINISH: begin
        // hold until the result register is free
        if (status.rsp_free) begin
          cmd.finish = 1'b1;
          state_next = aidtt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = aidtt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// Atom id translation table testbench
// Drives add, forward lookup, reverse lookup and clear requests: a short
// directed table, a table fill past capacity, then random phases under
// changing counter bases. Every response is compared with the directed row's
// expected result or with a local translation model.
// ---------------------------------------------------------------------------
module tb_top;
  import aidtt_pkg::*;

  localparam int LIMIT_TIME  = 40_000_000;
  localparam int HOLD_CYCLES = 3000;
  localparam int DIR_ROWS    = 20;

  typedef struct packed {
    logic [KEY_W-1:0] value;
    logic             found;
    logic             full;
    logic             empty;
  } xlat_result_t;

  typedef struct packed {
    kind_t            k;
    logic [KEY_W-1:0] id;
    logic [NUM_W-1:0] num;
    logic             typed;
    xlat_result_t     want;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_stall;
  kind_t            kind = KIND_ADD;
  logic [KEY_W-1:0] internal_id = '0;
  logic [NUM_W-1:0] external_number = '0;
  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  logic [KEY_W-1:0] result_value;
  logic             found;
  logic             table_full;
  logic             is_empty;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [NUM_W-1:0] cfg_data = '0;

  // translation model state
  logic [KEY_W-1:0] map_key [TABLE_ENTRIES];
  logic [NUM_W-1:0] map_num [TABLE_ENTRIES];
  int               fill_count = 0;
  logic [NUM_W-1:0] next_num = FIRST_NUMBER_RESET;
  logic [NUM_W-1:0] base_num = FIRST_NUMBER_RESET;

  xlat_result_t     pending [$];
  int               err_count = 0;
  int               rsp_count = 0;
  int               burst_left = 0;
  dir_row_t         dir_rows [DIR_ROWS];

  atom_id_translation_table i_dut (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .kind            (kind),
    .internal_id     (internal_id),
    .external_number (external_number),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .result_value    (result_value),
    .found           (found),
    .table_full      (table_full),
    .is_empty        (is_empty),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic xlat_result_t translate(input kind_t k, input logic [KEY_W-1:0] id,
                                             input logic [NUM_W-1:0] num);
    xlat_result_t r;
    int           hit;
    int           i;
    r   = '0;
    hit = -1;
    case (k)
      KIND_ADD, KIND_FWD: begin
        for (i = 0; i < fill_count; i++) begin
          if (hit < 0 && map_key[i] == id) hit = i;
        end
        if (hit >= 0) begin
          r.value = {16'h0, map_num[hit]};
          r.found = 1'b1;
        end else if (k == KIND_FWD) begin
          r.value = {16'h0, id[15:0]};
        end else if (fill_count == TABLE_ENTRIES) begin
          r.value = {16'h0, id[15:0]};
          r.full  = 1'b1;
        end else begin
          map_key[fill_count] = id;
          map_num[fill_count] = next_num;
          fill_count++;
          r.value  = {16'h0, next_num};
          next_num = next_num + 1'b1;
        end
      end
      KIND_REV: begin
        r.value = {16'h0, num};
        // lowest matching id wins when numbers repeat
        for (i = 0; i < fill_count; i++) begin
          if (map_num[i] == num && (!r.found || map_key[i] < r.value)) begin
            r.value = map_key[i];
            r.found = 1'b1;
          end
        end
      end
      default: begin
        fill_count = 0;
        next_num   = base_num;
      end
    endcase
    r.empty = (next_num == base_num);
    return r;
  endfunction

  task automatic send_req(input kind_t k, input logic [KEY_W-1:0] id,
                          input logic [NUM_W-1:0] num, input logic typed,
                          input xlat_result_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_valid       <= 1'b1;
    kind            <= k;
    internal_id     <= id;
    external_number <= num;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (typed) begin
      void'(translate(k, id, num));
      pending.push_back(want);
    end else begin
      pending.push_back(translate(k, id, num));
    end
  endtask

  task automatic random_request(input int clr_pct);
    int               r;
    kind_t            k;
    logic [KEY_W-1:0] id;
    logic [NUM_W-1:0] num;
    r   = $urandom_range(0, 99);
    id  = $urandom;
    num = $urandom_range(0, 65535);
    if (r < clr_pct) begin
      k = KIND_CLR;
    end else if (r < 35) begin
      k = KIND_ADD;
    end else if (r < 45) begin
      k = KIND_ADD;
      if (fill_count > 0) id = map_key[$urandom_range(0, fill_count - 1)];
    end else if (r < 62) begin
      k = KIND_FWD;
      if (fill_count > 0) id = map_key[$urandom_range(0, fill_count - 1)];
    end else if (r < 72) begin
      k = KIND_FWD;
    end else if (r < 89) begin
      k = KIND_REV;
      if (fill_count > 0) num = map_num[$urandom_range(0, fill_count - 1)];
    end else begin
      k = KIND_REV;
      // probe around the allocation counter
      if (r < 95) num = next_num + NUM_W'($urandom_range(0, 4)) - NUM_W'(2);
    end
    send_req(k, id, num, 1'b0, '0);
  endtask

  task automatic write_base(input logic [NUM_W-1:0] v);
    req_valid <= 1'b0;
    burst_left = 0;
    while (pending.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    base_num = v;
  endtask

  // response check
  always @(posedge clk) begin
    xlat_result_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      rsp_count++;
      if (pending.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("%0t unexpected response: value %h found %b full %b empty %b",
                   $time, result_value, found, table_full, is_empty);
      end else begin
        want = pending.pop_front();
        if (want.value !== result_value || want.found !== found ||
            want.full !== table_full || want.empty !== is_empty) begin
          err_count++;
          if (err_count <= 10)
            $display({"%0t response mismatch: value %h/%h found %b/%b full %b/%b",
                      " empty %b/%b (expected/actual)"},
                     $time, want.value, result_value, want.found, found,
                     want.full, table_full, want.empty, is_empty);
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  initial begin : rsp_side
    int  span;
    int  pct;
    bit  hold_done;
    span      = 0;
    pct       = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && rsp_count >= 700) begin
        hold_done = 1'b1;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        if (span == 0) begin
          span = $urandom_range(20, 400);
          case ($urandom_range(0, 3))
            0:       pct = 0;
            1:       pct = 20;
            2:       pct = 50;
            default: pct = 85;
          endcase
        end
        span--;
        rsp_stall <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  initial begin
    #LIMIT_TIME;
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int n;
    int ph;
    // counter base is 20000 (0x4E20) out of reset
    dir_rows = '{
      '{KIND_FWD, 32'hFFFF_FFFF, 16'h1234, 1'b1, '{32'h0000_FFFF, 1'b0, 1'b0, 1'b1}},
      '{KIND_REV, 32'h0000_0000, 16'hFFFF, 1'b1, '{32'h0000_FFFF, 1'b0, 1'b0, 1'b1}},
      '{KIND_REV, 32'hFFFF_FFFF, 16'h0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 1'b1}},
      '{KIND_FWD, 32'h0000_0000, 16'hFFFF, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 1'b1}},
      '{KIND_ADD, 32'hFFFF_FFFF, 16'h0000, 1'b1, '{32'h0000_4E20, 1'b0, 1'b0, 1'b0}},
      '{KIND_ADD, 32'h0000_0000, 16'hFFFF, 1'b1, '{32'h0000_4E21, 1'b0, 1'b0, 1'b0}},
      '{KIND_ADD, 32'hFFFF_FFFF, 16'h0000, 1'b1, '{32'h0000_4E20, 1'b1, 1'b0, 1'b0}},
      '{KIND_FWD, 32'hFFFF_FFFF, 16'h0000, 1'b1, '{32'h0000_4E20, 1'b1, 1'b0, 1'b0}},
      '{KIND_REV, 32'h1234_5678, 16'h4E21, 1'b1, '{32'h0000_0000, 1'b1, 1'b0, 1'b0}},
      '{KIND_REV, 32'h0000_0000, 16'h4E20, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0}},
      '{KIND_FWD, 32'h0001_4E20, 16'h0000, 1'b1, '{32'h0000_4E20, 1'b0, 1'b0, 1'b0}},
      '{KIND_REV, 32'h0000_0000, 16'h4E22, 1'b1, '{32'h0000_4E22, 1'b0, 1'b0, 1'b0}},
      '{KIND_CLR, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 1'b1}},
      '{KIND_ADD, 32'h8000_0001, 16'h0000, 1'b0, '{32'h0000_0000, 1'b0, 1'b0, 1'b0}},
      '{KIND_ADD, 32'h7FFF_FFFE, 16'hFFFF, 1'b0, '{32'h0000_0000, 1'b0, 1'b0, 1'b0}},
      '{KIND_REV, 32'h0000_0000, 16'h4E20, 1'b0, '{32'h0000_0000, 1'b0, 1'b0, 1'b0}},
      '{KIND_FWD, 32'h7FFF_FFFE, 16'h0000, 1'b0, '{32'h0000_0000, 1'b0, 1'b0, 1'b0}},
      '{KIND_REV, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, '{32'h0000_0000, 1'b0, 1'b0, 1'b0}},
      '{KIND_CLR, 32'h0000_0000, 16'h0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 1'b1}},
      '{KIND_REV, 32'h0000_0000, 16'h4E20, 1'b1, '{32'h0000_4E20, 1'b0, 1'b0, 1'b1}}
    };
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (n = 0; n < DIR_ROWS; n++)
      send_req(dir_rows[n].k, dir_rows[n].id, dir_rows[n].num, dir_rows[n].typed,
               dir_rows[n].want);

    // fill past capacity with the counter wrapping on the way
    write_base(16'd65400);
    send_req(KIND_CLR, $urandom, 16'($urandom), 1'b0, '0);
    for (n = 0; n < TABLE_ENTRIES + 6; n++) begin
      send_req(KIND_ADD, $urandom, 16'($urandom), 1'b0, '0);
      if (n % 8 == 7) random_request(0);
    end

    // new base leaves the counter alone until the next clear
    for (ph = 0; ph < 7; ph++) begin
      case (ph)
        0:       write_base(16'd0);
        1:       write_base(16'hFFFF);
        2:       write_base(next_num);
        default: write_base(16'($urandom));
      endcase
      repeat (250) random_request(3);
    end

    req_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (err_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end
endmodule
